// ----- hw/rtl/asfi_pkg.sv -----
// ----------------------------------------------------------------------------
// asfi_pkg
// Shared types and constants for the audio sample to int16 fade-in core.
// ----------------------------------------------------------------------------
package asfi_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_ROUND,
    ST_MULT,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } asfi_state_t;

  // Status from the fade divider
  typedef struct packed {
    logic busy;
    logic done;
  } asfi_div_sts_t;

  // Source formats
  localparam logic [2:0] FMT_F32   = 3'd0;
  localparam logic [2:0] FMT_PCM16 = 3'd1;
  localparam logic [2:0] FMT_PCM24 = 3'd2;
  localparam logic [2:0] FMT_PCM32 = 3'd3;
  localparam logic [2:0] FMT_PCM8  = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_SRC_FMT     = 2'd0;
  localparam logic [1:0] REG_CHAN_CNT    = 2'd1;
  localparam logic [1:0] REG_FADE_FRAMES = 2'd2;

  // Transaction kinds
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Register reset values
  localparam logic [2:0] SRC_FMT_RST     = FMT_F32;
  localparam logic [3:0] CHAN_CNT_RST    = 4'd2;
  localparam logic [9:0] FADE_FRAMES_RST = 10'd240;

  // Float32 conversion constants
  localparam logic [14:0] F32_SCALE      = 15'd32767;
  localparam logic [15:0] F32_FULL_SCALE = 16'd32767;
  localparam logic [7:0]  F32_EXP_ONE    = 8'd127;
  localparam logic [7:0]  F32_EXP_MAX    = 8'd255;
  localparam logic [7:0]  F32_SHIFT_BASE = 8'd150;
  localparam logic [7:0]  F32_SIG_BITS   = 8'd24;

  // Quotient width of the fade divider
  localparam int QUOT_W = 16;

endpackage

// ----- hw/rtl/asfi_div.sv -----
// ----------------------------------------------------------------------------
// asfi_div
// Restoring divider, one quotient bit per cycle, for a 16-bit quotient.
// The caller guarantees the quotient fits in 16 bits.
// ----------------------------------------------------------------------------
module asfi_div
  import asfi_pkg::*;
#(
  parameter int NUM_W = 27,
  parameter int DEN_W = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_W-1:0]    num,
  input  logic [DEN_W-1:0]    den,
  output asfi_div_sts_t       sts,
  output logic [QUOT_W-1:0]   quot
);

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [CNT_W-1:0]  cnt_r;
  logic              done_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [QUOT_W-1:0] quo_r;
  logic [DEN_W+1:0]  trial;
  logic              ge;

  // Trial subtract of the divisor from the shifted partial remainder
  assign trial = {1'b0, rem_r, quo_r[QUOT_W-1]} - {2'b00, den_r};
  assign ge    = ~trial[DEN_W+1];

  // Control: count iterations, pulse done after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(QUOT_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: high part seeds the remainder, low part shifts through
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[QUOT_W+DEN_W-1:QUOT_W];
      quo_r <= num[QUOT_W-1:0];
      den_r <= den;
    end else if (cnt_r != '0) begin
      if (ge) begin
        rem_r <= trial[DEN_W-1:0];
      end else begin
        rem_r <= {rem_r[DEN_W-2:0], quo_r[QUOT_W-1]};
      end
      quo_r <= {quo_r[QUOT_W-2:0], ge};
    end
  end

  assign sts.busy = (cnt_r != '0);
  assign sts.done = done_r;
  assign quot     = quo_r;

endmodule

// ----- hw/rtl/audio_sample_to_int16_with_fade_in_core.sv -----
// Path from accept to result: ST_CONV, ST_ROUND, ST_DONE without fade; with fade
// active, ST_MULT, ST_LOAD and the bit-serial fade divider (ST_DIV) come before ST_DONE.
// Throughput: one item at a time; next item accepted once the result has
// entered the output register; a restart is taken without leaving idle.
// Reset (synchronous, rst_n low): registers to defaults, no fade active,
// channel position zero, output empty.
// ----------------------------------------------------------------------------
// audio_sample_to_int16_with_fade_in_core
// Converts one raw interleaved audio sample to signed 16-bit by source
// format and applies a linear fade-in armed by a restart transaction.
// ----------------------------------------------------------------------------
module audio_sample_to_int16_with_fade_in_core
  import asfi_pkg::*;
#(
  parameter int MAX_CHANNELS = 8,
  parameter int FADE_WIDTH   = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] sample_in
  input  logic [1:0]  in_tuser,    // [0] op, [1] silent
  input  logic        in_tlast,    // packet_end
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] sample_out
  output logic        out_tlast,   // packet_end_out
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CPW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int FW    = FADE_WIDTH;
  localparam int PROD_W = FW + 17;
  localparam int NUM_W = FW + 17;
  localparam int DEN_W = FW + 1;
  localparam logic [16:0] FADE_LIM = 17'((1 << FW) - 1);
  localparam logic [4:0]  MAX_CH   = 5'(MAX_CHANNELS);

  // Configuration registers
  logic [2:0] src_fmt_r;
  logic [3:0] chan_cnt_r;
  logic [9:0] fade_frames_r;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  // Frame and fade state
  logic [FW-1:0]  fade_left_r;
  logic [CPW-1:0] chan_pos_r;

  // Per-item registers
  asfi_state_t     state_r, state_nxt;
  logic [31:0]     samp_r;
  logic            silent_r;
  logic            pend_r;
  logic            fade_act_r;
  logic [FW-1:0]   k_r;
  logic [FW-1:0]   t_r;
  logic [38:0]     p_r;
  logic [15:0]     x_r;
  logic [PROD_W-1:0] prod_r;

  // Output register
  logic        out_tvalid_r;
  logic [15:0] out_tdata_r;
  logic        out_tlast_r;

  // Sequencer outputs
  logic in_acc;
  logic div_start;
  logic out_load;

  // Combinational helpers
  logic [16:0]    ff_ext;
  logic [16:0]    t_wide;
  logic [FW-1:0]  t_len;
  logic [4:0]     chans;
  logic           frame_end;
  logic [FW-1:0]  fade_r;
  logic [FW-1:0]  k_nxt;

  logic [23:0] f_m;
  logic        f_big;
  logic [23:0] f_q;
  logic [14:0] f_rem;
  logic [14:0] f_half;
  logic        f_up;
  logic [24:0] f_q1;
  logic [7:0]  f_sh;
  logic [7:0]  f_amt;
  logic [7:0]  f_exp;
  logic [22:0] f_frac;
  logic [15:0] f_mag_n;
  logic [15:0] f_mag;
  logic [15:0] f_val;
  logic [15:0] conv;

  logic [15:0]       x_mag;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  asfi_div_sts_t     div_sts;
  logic [QUOT_W-1:0] div_quot;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r     <= SRC_FMT_RST;
      chan_cnt_r    <= CHAN_CNT_RST;
      fade_frames_r <= FADE_FRAMES_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SRC_FMT:     src_fmt_r     <= cfg_pwdata[2:0];
        REG_CHAN_CNT:    chan_cnt_r    <= cfg_pwdata[3:0];
        REG_FADE_FRAMES: fade_frames_r <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (cfg_idx)
      REG_SRC_FMT:     cfg_prdata = {29'd0, src_fmt_r};
      REG_CHAN_CNT:    cfg_prdata = {28'd0, chan_cnt_r};
      REG_FADE_FRAMES: cfg_prdata = {22'd0, fade_frames_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Fade length and channel count with their limits applied
  // --------------------------------------------------------------------------
  assign ff_ext = {7'd0, fade_frames_r};
  assign t_wide = (ff_ext == 17'd0) ? 17'd1 : ((ff_ext > FADE_LIM) ? FADE_LIM : ff_ext);
  assign t_len  = t_wide[FW-1:0];

  always_comb begin
    if (chan_cnt_r == 4'd0) begin
      chans = 5'd1;
    end else if ({1'b0, chan_cnt_r} > MAX_CH) begin
      chans = MAX_CH;
    end else begin
      chans = {1'b0, chan_cnt_r};
    end
  end

  assign frame_end = (5'(chan_pos_r) + 5'd1) >= chans;
  assign fade_r    = (fade_left_r < t_len) ? fade_left_r : t_len;
  assign k_nxt     = t_len - fade_r + FW'(1);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc && in_tuser[0] == OP_SAMPLE) state_nxt = ST_CONV;
      ST_CONV:  state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = fade_act_r ? ST_MULT : ST_DONE;
      ST_MULT:  state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_DIV;
      ST_DIV:   if (div_sts.done) state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_LOAD: div_start = 1'b1;
      ST_DONE: out_load  = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Frame position and fade counter, advanced at accept
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_left_r <= '0;
      chan_pos_r  <= '0;
      fade_act_r  <= 1'b0;
    end else if (in_acc) begin
      if (in_tuser[0] == OP_RESTART) begin
        fade_left_r <= t_len;
        chan_pos_r  <= '0;
      end else begin
        fade_act_r <= (fade_left_r != '0);
        if (fade_left_r != '0 && frame_end) begin
          fade_left_r <= fade_r - FW'(1);
        end
        if (frame_end || in_tlast) begin
          chan_pos_r <= '0;
        end else begin
          chan_pos_r <= chan_pos_r + CPW'(1);
        end
      end
    end
  end

  // Capture the sample and its fade factor
  always_ff @(posedge clk) begin
    if (in_acc) begin
      samp_r   <= in_tdata;
      silent_r <= in_tuser[1];
      pend_r   <= in_tlast;
      k_r      <= k_nxt;
      t_r      <= t_len;
    end
  end

  // --------------------------------------------------------------------------
  // Format conversion
  // --------------------------------------------------------------------------
  assign f_exp  = samp_r[30:23];
  assign f_frac = samp_r[22:0];
  assign f_m    = {f_exp != 8'd0, f_frac};

  // Round the scaled significand to 24 bits, ties to even
  assign f_big  = p_r[38];
  assign f_q    = f_big ? p_r[38:15] : p_r[37:14];
  assign f_rem  = f_big ? p_r[14:0] : {1'b0, p_r[13:0]};
  assign f_half = f_big ? 15'h4000 : 15'h2000;
  assign f_up   = (f_rem > f_half) || (f_rem == f_half && f_q[0]);
  assign f_q1   = {1'b0, f_q} + 25'(f_up);

  // Truncate toward zero: shift right by 150 less the exponent, less the rounding drop
  assign f_sh    = F32_SHIFT_BASE - f_exp;
  assign f_amt   = f_sh - (f_big ? 8'd15 : 8'd14);
  assign f_mag_n = (f_amt > F32_SIG_BITS) ? 16'd0 : 16'(f_q1 >> f_amt);

  always_comb begin
    if (f_exp == F32_EXP_MAX && f_frac != 23'd0) begin
      f_mag = 16'd0;
    end else if (f_exp >= F32_EXP_ONE) begin
      f_mag = F32_FULL_SCALE;
    end else if (f_exp == 8'd0) begin
      f_mag = 16'd0;
    end else begin
      f_mag = f_mag_n;
    end
  end

  assign f_val = samp_r[31] ? (16'd0 - f_mag) : f_mag;

  always_comb begin
    case (src_fmt_r)
      FMT_F32:   conv = f_val;
      FMT_PCM16: conv = samp_r[15:0];
      FMT_PCM24: conv = samp_r[23:8];
      FMT_PCM32: conv = samp_r[31:16];
      FMT_PCM8:  conv = {~samp_r[7], samp_r[6:0], 8'h00};
      default:   conv = 16'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  assign x_mag   = x_r[15] ? (16'd0 - x_r) : x_r;
  assign div_num = NUM_W'(prod_r) + NUM_W'(t_r);
  assign div_den = {t_r, 1'b0};

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_CONV:  p_r <= 39'(f_m) * 39'(F32_SCALE);
      ST_ROUND: x_r <= silent_r ? 16'd0 : conv;
      ST_MULT:  prod_r <= PROD_W'({x_mag, 1'b0}) * PROD_W'(k_r);
      ST_DIV: begin
        if (div_sts.done) begin
          x_r <= x_r[15] ? (16'd0 - div_quot) : div_quot;
        end
      end
      default: ;
    endcase
  end

  asfi_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .sts   (div_sts),
    .quot  (div_quot)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= x_r;
      out_tlast_r <= pend_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_sts.busy)
    else $error("fade divider started while busy");

  a_fade_not_amplify: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_sts.done) |-> (div_quot <= x_mag))
    else $error("fade quotient exceeds sample magnitude");

  a_restart_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser[0] == OP_RESTART) |=> (fade_left_r == $past(t_len)))
    else $error("restart did not arm the fade length");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |=> (out_tvalid_r && $stable(out_tdata_r)))
    else $error("pending result overwritten");

endmodule

// ----- test/audio_sample_to_int16_with_fade_in_core_test.sv -----
// ----------------------------------------------------------------------------
// audio_sample_to_int16_with_fade_in_core_test
// Self-checking bench for the sample converter with fade-in. A directed table
// covers the format extremes, the special float values, silent samples and
// restarts. Random phases then sweep register settings, mostly as
// restart-plus-frames sequences. Every result is checked against an in-bench
// predictor or a fixed table value, with random idle gaps on input and result.
// ----------------------------------------------------------------------------
module audio_sample_to_int16_with_fade_in_core_test
  import asfi_pkg::*;
();

  localparam int ITEMS_TARGET = 800;
  localparam int MAX_CH       = 8;
  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT  = 600000;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [1:0]        reg_idx;
    logic [31:0]       reg_val;
    logic              op;
    logic [31:0]       smp;
    logic              sil;
    logic              last;
    logic              has_fixed;
    logic signed [15:0] fixed_val;
  } stim_row_t;

  typedef struct {
    logic signed [15:0] sample;
    logic               last;
  } sample_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;     // [31:0] sample_in
  logic [1:0]  in_tuser = '0;     // [0] op, [1] silent
  logic        in_tlast = 1'b0;   // packet_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [15:0] sample_out
  logic        out_tlast;         // packet_end_out
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  audio_sample_to_int16_with_fade_in_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Predictor state and register copies
  logic [2:0]  fmt_reg  = SRC_FMT_RST;
  logic [3:0]  chan_reg = CHAN_CNT_RST;
  logic [9:0]  fade_reg = FADE_FRAMES_RST;
  int          fade_rem = 0;
  int          chan_idx = 0;

  sample_rec_t expected_q[$];
  stim_row_t   dir_rows[$];
  int          errors = 0;
  int          items_sent = 0;
  int          restarts_sent = 0;
  int          results_seen = 0;
  int          settings_used = 0;
  int          cycle_cnt = 0;
  int          stall_left = 0;
  logic        calm = 1'b0;

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("audio_sample_to_int16_with_fade_in_core_test: FAIL");
      $finish;
    end
  end

  // Random gap length: mostly none, some short, a few long
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Float32 bits to signed 16-bit: clamp, scale by 32767, round to single, truncate
  function automatic int f32_to_int16(logic [31:0] bits);
    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] fr;
    logic [63:0] m, p, q, rem, half, r;
    int          shift, len, d, mag;
    sgn = bits[31];
    ex  = bits[30:23];
    fr  = bits[22:0];
    if (ex == F32_EXP_MAX && fr != 0) return 0;
    if (ex >= F32_EXP_ONE) begin
      mag = 32767;
    end else begin
      if (ex == 0) begin
        m = {41'd0, fr};
        shift = 149;
      end else begin
        m = {40'd0, 1'b1, fr};
        shift = 150 - int'(ex);
      end
      p = m * 64'd32767;
      len = 0;
      for (int i = 0; i < 64; i++) begin
        if (p[i]) len = i + 1;
      end
      if (len > 24) begin
        d = len - 24;
        q = p >> d;
        rem = p & ((64'd1 << d) - 64'd1);
        half = 64'd1 << (d - 1);
        if (rem > half || (rem == half && q[0])) q = q + 64'd1;
        r = q << d;
      end else begin
        r = p;
      end
      mag = (shift > 63) ? 0 : int'(r >> shift);
    end
    return sgn ? -mag : mag;
  endfunction

  // Raw sample to signed 16-bit under the current source format
  function automatic int raw_to_int16(logic [31:0] smp);
    logic [15:0] v;
    case (fmt_reg)
      FMT_F32:   return f32_to_int16(smp);
      FMT_PCM16: v = smp[15:0];
      FMT_PCM24: v = smp[23:8];
      FMT_PCM32: v = smp[31:16];
      FMT_PCM8:  v = {smp[7] ^ 1'b1, smp[6:0], 8'h00};
      default:   return 0;
    endcase
    return int'($signed(v));
  endfunction

  // Advance the predictor by one transaction; produced is low on a restart
  function automatic void fade_convert(input logic op, input logic [31:0] smp,
                                       input logic sil, input logic last,
                                       output logic produced, output sample_rec_t rec);
    int     t, chans, x, r, k;
    longint mag, q;
    t = (fade_reg == 0) ? 1 : int'(fade_reg);
    chans = (chan_reg == 0) ? 1 : ((int'(chan_reg) > MAX_CH) ? MAX_CH : int'(chan_reg));
    produced = 1'b0;
    rec.sample = '0;
    rec.last = 1'b0;
    if (op == OP_RESTART) begin
      fade_rem = t;
      chan_idx = 0;
      return;
    end
    x = sil ? 0 : raw_to_int16(smp);
    if (fade_rem > 0) begin
      r = (fade_rem < t) ? fade_rem : t;
      k = t - r + 1;
      mag = (x < 0) ? -x : x;
      q = (2 * mag * k + t) / (2 * t);
      x = (x < 0) ? -int'(q) : int'(q);
      if (chan_idx + 1 >= chans) fade_rem = r - 1;
    end
    if (chan_idx + 1 >= chans || last) chan_idx = 0;
    else chan_idx = chan_idx + 1;
    produced = 1'b1;
    rec.sample = x[15:0];
    rec.last = last;
  endfunction

  // Hold the input idle until every expected result has arrived, then settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register, read it back, and update the predictor copy
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] mask;
    case (idx)
      REG_SRC_FMT:     mask = 32'h7;
      REG_CHAN_CNT:    mask = 32'hF;
      REG_FADE_FRAMES: mask = 32'h3FF;
      default:         mask = 32'h0;
    endcase
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    // read back in a fresh setup and access pair
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== (val & mask)) begin
      errors++;
      $display("%0t: register %0d readback: expected %0h, actual %0h",
               $time, idx, val & mask, cfg_prdata);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_SRC_FMT:     fmt_reg = val[2:0];
      REG_CHAN_CNT:    chan_reg = val[3:0];
      REG_FADE_FRAMES: fade_reg = val[9:0];
      default: ;
    endcase
  endtask

  // Drive one input transaction and queue its expected result
  task automatic send_item(input logic op, input logic [31:0] smp, input logic sil,
                           input logic last, input logic has_fixed,
                           input logic signed [15:0] fixed_val);
    int          gap;
    logic        produced;
    sample_rec_t rec;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    in_tuser  <= {sil, op};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (op == OP_RESTART) restarts_sent++;
    fade_convert(op, smp, sil, last, produced, rec);
    if (produced) begin
      if (has_fixed) rec.sample = fixed_val;
      expected_q.push_back(rec);
    end
  endtask

  // Directed table helpers
  function automatic void add_cfg(logic [1:0] idx, logic [31:0] val);
    stim_row_t row;
    row = '{ROW_CFG, idx, val, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0, 16'sd0};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_item(logic op, logic [31:0] smp, logic sil, logic last,
                                   logic has_fixed, logic signed [15:0] fixed_val);
    stim_row_t row;
    row = '{ROW_ITEM, REG_SRC_FMT, 32'd0, op, smp, sil, last, has_fixed, fixed_val};
    dir_rows.push_back(row);
  endfunction

  // Random raw sample shaped by the current format
  function automatic logic [31:0] rand_sample();
    logic [7:0] ex;
    if (fmt_reg == FMT_F32) begin
      case ($urandom_range(0, 3))
        0: return $urandom;
        3: begin
          case ($urandom_range(0, 3))
            0: ex = 8'd0;
            1: ex = F32_EXP_ONE;
            2: ex = F32_EXP_MAX;
            default: ex = 8'd128;
          endcase
          return {1'($urandom), ex, ($urandom_range(0, 1) == 0) ? 23'd0 : 23'($urandom)};
        end
        default: return {1'($urandom), 8'($urandom_range(100, 126)), 23'($urandom)};
      endcase
    end
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_7FFF;
      1: return 32'h8080_8080;
      2: return ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Result side: random backpressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left <= gap_len();
    end
  end

  // Result checker
  always @(posedge clk) begin
    sample_rec_t exp_rec;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %0d last %0b",
                 $time, $signed(out_tdata), out_tlast);
      end else begin
        exp_rec = expected_q.pop_front();
        if (out_tdata !== exp_rec.sample) begin
          errors++;
          $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                   $time, exp_rec.sample, $signed(out_tdata));
        end
        if (out_tlast !== exp_rec.last) begin
          errors++;
          $display("%0t: packet_end_out mismatch: expected %0b, actual %0b",
                   $time, exp_rec.last, out_tlast);
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [2:0]  fmt_pick;
    logic [3:0]  chan_pick;
    logic [9:0]  fade_pick;
    int          burst;
    int          phase;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: defaults after reset are float32, 2 channels, no fade
    add_item(OP_SAMPLE, 32'h3F80_0000, 1'b0, 1'b0, 1'b1, 16'sd32767);   // +1.0
    add_item(OP_SAMPLE, 32'hBF80_0000, 1'b0, 1'b0, 1'b1, -16'sd32767);  // -1.0
    add_item(OP_SAMPLE, 32'h7FC0_0000, 1'b0, 1'b0, 1'b1, 16'sd0);       // NaN
    add_item(OP_SAMPLE, 32'h7F80_0000, 1'b0, 1'b0, 1'b1, 16'sd32767);   // +inf
    add_item(OP_SAMPLE, 32'hFF80_0000, 1'b0, 1'b0, 1'b1, -16'sd32767);  // -inf
    add_item(OP_SAMPLE, 32'h3F00_0000, 1'b0, 1'b0, 1'b1, 16'sd16383);   // 0.5
    add_item(OP_SAMPLE, 32'h0000_0001, 1'b0, 1'b0, 1'b1, 16'sd0);       // denormal
    add_item(OP_SAMPLE, 32'h8000_0000, 1'b0, 1'b0, 1'b1, 16'sd0);       // -0.0
    add_item(OP_SAMPLE, 32'h3F7F_FFFF, 1'b0, 1'b0, 1'b0, 16'sd0);       // just below 1
    add_item(OP_SAMPLE, 32'h3F80_0000, 1'b1, 1'b1, 1'b1, 16'sd0);       // silent
    add_cfg(REG_SRC_FMT, FMT_PCM16);
    add_item(OP_SAMPLE, 32'h0000_7FFF, 1'b0, 1'b0, 1'b1, 16'sd32767);
    add_item(OP_SAMPLE, 32'hFFFF_8000, 1'b0, 1'b0, 1'b1, -16'sd32768);
    add_cfg(REG_SRC_FMT, FMT_PCM24);
    add_item(OP_SAMPLE, 32'h0080_0000, 1'b0, 1'b0, 1'b1, -16'sd32768);
    add_item(OP_SAMPLE, 32'h007F_FFFF, 1'b0, 1'b0, 1'b1, 16'sd32767);
    add_cfg(REG_SRC_FMT, FMT_PCM32);
    add_item(OP_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1, 16'sd32767);
    add_item(OP_SAMPLE, 32'h8000_0000, 1'b0, 1'b0, 1'b1, -16'sd32768);
    add_cfg(REG_SRC_FMT, FMT_PCM8);
    add_item(OP_SAMPLE, 32'h0000_0000, 1'b0, 1'b0, 1'b1, -16'sd32768);
    add_item(OP_SAMPLE, 32'h0000_00FF, 1'b0, 1'b0, 1'b1, 16'sd32512);
    add_item(OP_SAMPLE, 32'h0000_0080, 1'b0, 1'b1, 1'b1, 16'sd0);
    add_cfg(REG_SRC_FMT, 32'd5);
    add_item(OP_SAMPLE, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 16'sd0);       // unsupported
    add_cfg(REG_SRC_FMT, 32'd7);
    add_item(OP_SAMPLE, 32'h1234_5678, 1'b0, 1'b0, 1'b1, 16'sd0);
    // zero fade length acts as one frame, zero channels as one
    add_cfg(REG_SRC_FMT, FMT_PCM16);
    add_cfg(REG_CHAN_CNT, 32'd0);
    add_cfg(REG_FADE_FRAMES, 32'd0);
    add_item(OP_RESTART, 32'd0, 1'b0, 1'b0, 1'b0, 16'sd0);
    add_item(OP_SAMPLE, 32'h0000_8001, 1'b0, 1'b0, 1'b0, 16'sd0);
    add_item(OP_SAMPLE, 32'h0000_7FFF, 1'b0, 1'b0, 1'b0, 16'sd0);
    // restart and packet end in the middle of a frame
    add_cfg(REG_CHAN_CNT, 32'd3);
    add_cfg(REG_FADE_FRAMES, 32'd4);
    add_item(OP_RESTART, 32'd0, 1'b0, 1'b0, 1'b0, 16'sd0);
    add_item(OP_SAMPLE, 32'h0000_7FFF, 1'b0, 1'b0, 1'b0, 16'sd0);
    add_item(OP_RESTART, 32'd0, 1'b0, 1'b0, 1'b0, 16'sd0);
    add_item(OP_SAMPLE, 32'h0000_8000, 1'b0, 1'b0, 1'b0, 16'sd0);
    add_item(OP_SAMPLE, 32'h0000_1235, 1'b0, 1'b1, 1'b0, 16'sd0);
    add_item(OP_SAMPLE, 32'h0000_7FFF, 1'b1, 1'b0, 1'b0, 16'sd0);
    add_item(OP_SAMPLE, 32'h0000_C001, 1'b0, 1'b0, 1'b0, 16'sd0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_results();
        cfg_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_item(dir_rows[i].op, dir_rows[i].smp, dir_rows[i].sil, dir_rows[i].last,
                  dir_rows[i].has_fixed, dir_rows[i].fixed_val);
      end
    end

    // Random phases: new settings, then restart-plus-frames traffic
    phase = 0;
    while (items_sent < ITEMS_TARGET) begin
      case (phase)
        0: begin fmt_pick = FMT_F32;   chan_pick = 4'd0;  fade_pick = 10'd0;    end
        1: begin fmt_pick = FMT_PCM16; chan_pick = 4'd15; fade_pick = 10'd1023; end
        2: begin fmt_pick = FMT_PCM8;  chan_pick = 4'd8;  fade_pick = 10'd1;    end
        3: begin fmt_pick = 3'd7;      chan_pick = 4'd1;  fade_pick = 10'd2;    end
        default: begin
          fmt_pick = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) : 3'($urandom);
          chan_pick = 4'($urandom);
          case ($urandom_range(0, 9))
            0: fade_pick = 10'd0;
            1: fade_pick = 10'($urandom);
            default: fade_pick = 10'($urandom_range(1, 12));
          endcase
        end
      endcase
      drain_results();
      cfg_write(REG_SRC_FMT, {29'd0, fmt_pick});
      cfg_write(REG_CHAN_CNT, {28'd0, chan_pick});
      // leave fade length as is now and then so a phase may keep the previous length
      if (phase < 4 || $urandom_range(0, 4) != 0)
        cfg_write(REG_FADE_FRAMES, {22'd0, fade_pick});
      settings_used++;
      calm = (phase % 5 == 3);

      if ($urandom_range(0, 9) < 8)
        send_item(OP_RESTART, $urandom, 1'($urandom), 1'($urandom), 1'b0, 16'sd0);
      burst = $urandom_range(40, 90);
      repeat (burst) begin
        if ($urandom_range(0, 59) == 0) drain_results();
        if ($urandom_range(0, 24) == 0)
          send_item(OP_RESTART, $urandom, 1'($urandom), 1'($urandom), 1'b0, 16'sd0);
        else
          send_item(OP_SAMPLE, rand_sample(), $urandom_range(0, 11) == 0,
                    $urandom_range(0, 9) == 0, 1'b0, 16'sd0);
      end
      phase++;
    end

    drain_results();
    $display("run covered %0d input transactions (%0d restarts) and %0d results",
             items_sent, restarts_sent, results_seen);
    $display("across %0d register settings plus the directed table", settings_used);
    if (errors == 0) begin
      $display("audio_sample_to_int16_with_fade_in_core_test: PASS");
    end else begin
      $display("audio_sample_to_int16_with_fade_in_core_test: FAIL");
    end
    $finish;
  end

endmodule
